### hw/rtl/hue_band_color_mask_top_macros.svh
// Assertion macros shared by the hue band color mask RTL.
`ifndef HUE_BAND_COLOR_MASK_TOP_MACROS_SVH
`define HUE_BAND_COLOR_MASK_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HBCM_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbcm assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define HBCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbcm assertion failed");

`endif

### hw/rtl/hbcm_pkg.sv
// Shared types, register indexes and constants of the hue band color mask.
package hbcm_pkg;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned NUM_W     = 12;
    localparam int unsigned RECIP_W   = 20;
    localparam int unsigned RECIP_N   = 256;
    localparam int unsigned PROD_W    = 33;
    localparam int unsigned SCALED_W  = 37;
    localparam int unsigned HUE_SHIFT = 19;
    localparam int unsigned HUE_W     = SCALED_W - HUE_SHIFT;
    localparam int unsigned RECIP_NUM = 1044480;

    localparam logic signed [SCALED_W-1:0] HUE_ROUND = 37'sd262144;
    localparam logic signed [HUE_W-1:0]    HUE_RANGE = 18'sd180;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BAND_SELECT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_ABOVE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_BELOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_MIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_MIN   = 3'd6;

    localparam logic              RST_BAND_SELECT = 1'b1;
    localparam logic [CHAN_W-1:0] RST_INNER_LOW   = 8'd90;
    localparam logic [CHAN_W-1:0] RST_INNER_HIGH  = 8'd130;
    localparam logic [CHAN_W-1:0] RST_WRAP_ABOVE  = 8'd160;
    localparam logic [CHAN_W-1:0] RST_WRAP_BELOW  = 8'd20;
    localparam logic [CHAN_W-1:0] RST_CHROMA_MIN  = 8'd10;
    localparam logic [CHAN_W-1:0] RST_LIGHT_MIN   = 8'd110;

    typedef struct packed {
        logic              band_select;
        logic [CHAN_W-1:0] inner_low;
        logic [CHAN_W-1:0] inner_high;
        logic [CHAN_W-1:0] wrap_above;
        logic [CHAN_W-1:0] wrap_below;
        logic [CHAN_W-1:0] chroma_min;
        logic [CHAN_W-1:0] light_min;
    } cfg_t;

    typedef struct packed {
        logic                    cand;
        logic                    last;
        logic [CHAN_W-1:0]       diff;
        logic signed [NUM_W-1:0] num;
    } sect_t;

    typedef struct packed {
        logic                    cand;
        logic                    last;
        logic signed [HUE_W-1:0] hue;
    } hue_t;

endpackage

### hw/rtl/hbcm_extrema.sv
// First pipeline stage: channel extrema, candidate test and sector numerator.
module hbcm_extrema
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  hbcm_pkg::cfg_t                cfg,
    input  logic                          pix_valid,
    output logic                          pix_ready,
    input  logic [hbcm_pkg::CHAN_W-1:0]   blue,
    input  logic [hbcm_pkg::CHAN_W-1:0]   green,
    input  logic [hbcm_pkg::CHAN_W-1:0]   red,
    input  logic                          last_pixel,
    output logic                          sect_valid,
    input  logic                          sect_ready,
    output hbcm_pkg::sect_t               sect
);

    logic [hbcm_pkg::CHAN_W-1:0]       max_bg;
    logic [hbcm_pkg::CHAN_W-1:0]       min_bg;
    logic [hbcm_pkg::CHAN_W-1:0]       vmax;
    logic [hbcm_pkg::CHAN_W-1:0]       vmin;
    logic [hbcm_pkg::CHAN_W-1:0]       diff;
    logic [hbcm_pkg::CHAN_W:0]         light_sum;
    logic signed [hbcm_pkg::NUM_W-1:0] b_ext;
    logic signed [hbcm_pkg::NUM_W-1:0] g_ext;
    logic signed [hbcm_pkg::NUM_W-1:0] r_ext;
    logic signed [hbcm_pkg::NUM_W-1:0] d_ext;
    logic                              valid_reg;
    hbcm_pkg::sect_t                   sect_reg;
    hbcm_pkg::sect_t                   sect_next;

    assign max_bg    = (green > blue) ? green : blue;
    assign vmax      = (red > max_bg) ? red : max_bg;
    assign min_bg    = (green < blue) ? green : blue;
    assign vmin      = (red < min_bg) ? red : min_bg;
    assign diff      = vmax - vmin;
    assign light_sum = {1'b0, vmax} + {1'b0, vmin};

    assign b_ext = $signed({4'b0000, blue});
    assign g_ext = $signed({4'b0000, green});
    assign r_ext = $signed({4'b0000, red});
    assign d_ext = $signed({4'b0000, diff});

    always_comb
    begin
        sect_next.cand = (diff > cfg.chroma_min)
                         && (light_sum[hbcm_pkg::CHAN_W:1] > cfg.light_min);
        sect_next.last = last_pixel;
        sect_next.diff = diff;
        if (vmax == red)
        begin
            sect_next.num = g_ext - b_ext;
        end
        else if (vmax == green)
        begin
            sect_next.num = b_ext - r_ext + (d_ext <<< 1);
        end
        else
        begin
            sect_next.num = r_ext - g_ext + (d_ext <<< 2);
        end
    end

    assign pix_ready = !valid_reg || sect_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pix_ready)
        begin
            valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_valid && pix_ready)
        begin
            sect_reg <= sect_next;
        end
    end

    assign sect_valid = valid_reg;
    assign sect       = sect_reg;

endmodule

### hw/rtl/hbcm_hue.sv
// Hue stages: reciprocal lookup, sector multiply, then scale, round and shift.
`include "hue_band_color_mask_top_macros.svh"

module hbcm_hue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sect_valid,
    output logic            sect_ready,
    input  hbcm_pkg::sect_t sect,
    output logic            hue_valid,
    input  logic            hue_ready,
    output hbcm_pkg::hue_t  hue
);

    logic [hbcm_pkg::RECIP_W-1:0] recip_tab [hbcm_pkg::RECIP_N];

    for (genvar i = 0; i < hbcm_pkg::RECIP_N; i++)
    begin : g_recip
        localparam int unsigned DIV = (i == 0) ? 1 : i;
        localparam int unsigned RV  = (i == 0) ? 0 : (hbcm_pkg::RECIP_NUM + i / 2) / DIV;
        assign recip_tab[i] = 20'(RV);
    end

    logic                                 va_reg;
    logic                                 cand_a_reg;
    logic                                 last_a_reg;
    logic signed [hbcm_pkg::NUM_W-1:0]    num_a_reg;
    logic [hbcm_pkg::RECIP_W-1:0]         recip_a_reg;

    logic                                 vb_reg;
    logic                                 cand_b_reg;
    logic                                 last_b_reg;
    logic signed [hbcm_pkg::PROD_W-1:0]   prod_b_reg;
    logic signed [hbcm_pkg::PROD_W-1:0]   prod_b_next;

    logic                                 vc_reg;
    hbcm_pkg::hue_t                       hue_c_reg;
    hbcm_pkg::hue_t                       hue_c_next;
    logic signed [hbcm_pkg::SCALED_W-1:0] prod_ext;
    logic signed [hbcm_pkg::SCALED_W-1:0] scaled;

    logic                                 en_a;
    logic                                 en_b;
    logic                                 en_c;

    assign en_c       = !vc_reg || hue_ready;
    assign en_b       = !vb_reg || en_c;
    assign en_a       = !va_reg || en_b;
    assign sect_ready = en_a;

    assign prod_b_next = num_a_reg * $signed({1'b0, recip_a_reg});

    // Times fifteen is sixteen times less once; the floor shift is a plain bit select.
    assign prod_ext = 37'(prod_b_reg);
    assign scaled   = (prod_ext <<< 4) - prod_ext + hbcm_pkg::HUE_ROUND;

    always_comb
    begin
        hue_c_next.cand = cand_b_reg;
        hue_c_next.last = last_b_reg;
        hue_c_next.hue  = $signed(scaled[hbcm_pkg::SCALED_W-1:hbcm_pkg::HUE_SHIFT]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                va_reg <= sect_valid;
            end
            if (en_b)
            begin
                vb_reg <= va_reg;
            end
            if (en_c)
            begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sect_valid && en_a)
        begin
            cand_a_reg  <= sect.cand;
            last_a_reg  <= sect.last;
            num_a_reg   <= sect.num;
            recip_a_reg <= recip_tab[sect.diff];
        end
        if (va_reg && en_b)
        begin
            cand_b_reg <= cand_a_reg;
            last_b_reg <= last_a_reg;
            prod_b_reg <= prod_b_next;
        end
        if (vb_reg && en_c)
        begin
            hue_c_reg <= hue_c_next;
        end
    end

    assign hue_valid = vc_reg;
    assign hue       = hue_c_reg;

    `HBCM_ASSERT_NEXT(a_prod_holds_on_stall, vb_reg && !en_c, vb_reg && $stable(prod_b_reg))
    `HBCM_ASSERT(a_hue_bounded, vc_reg && hue_c_reg.cand,
        hue_c_reg.hue >= -18'sd32 && hue_c_reg.hue <= 18'sd180)

endmodule

### hw/rtl/hbcm_band.sv
// Output stage: hue wrap to the 0..180 scale and the selected band test.
`include "hue_band_color_mask_top_macros.svh"

module hbcm_band
(
    input  logic           clk,
    input  logic           rst_n,
    input  hbcm_pkg::cfg_t cfg,
    input  logic           hue_valid,
    output logic           hue_ready,
    input  hbcm_pkg::hue_t hue,
    output logic           mask_valid,
    input  logic           mask_ready,
    output logic           mask_on,
    output logic           last_out
);

    logic signed [hbcm_pkg::HUE_W-1:0] hue_adj;
    logic signed [hbcm_pkg::HUE_W-1:0] inner_low_ext;
    logic signed [hbcm_pkg::HUE_W-1:0] inner_high_ext;
    logic signed [hbcm_pkg::HUE_W-1:0] wrap_above_ext;
    logic signed [hbcm_pkg::HUE_W-1:0] wrap_below_ext;
    logic                              valid_reg;
    logic                              mask_reg;
    logic                              mask_next;
    logic                              last_reg;

    assign hue_adj = (hue.hue < 0) ? (hue.hue + hbcm_pkg::HUE_RANGE) : hue.hue;

    assign inner_low_ext  = $signed({10'b0, cfg.inner_low});
    assign inner_high_ext = $signed({10'b0, cfg.inner_high});
    assign wrap_above_ext = $signed({10'b0, cfg.wrap_above});
    assign wrap_below_ext = $signed({10'b0, cfg.wrap_below});

    always_comb
    begin
        if (!hue.cand)
        begin
            mask_next = 1'b0;
        end
        else if (cfg.band_select)
        begin
            mask_next = (hue_adj > inner_low_ext) && (hue_adj < inner_high_ext);
        end
        else
        begin
            mask_next = (hue_adj > wrap_above_ext) || (hue_adj < wrap_below_ext);
        end
    end

    assign hue_ready = !valid_reg || mask_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (hue_ready)
        begin
            valid_reg <= hue_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hue_valid && hue_ready)
        begin
            mask_reg <= mask_next;
            last_reg <= hue.last;
        end
    end

    assign mask_valid = valid_reg;
    assign mask_on    = mask_reg;
    assign last_out   = last_reg;

    `HBCM_ASSERT_NEXT(a_weak_pixel_masked, hue_valid && hue_ready && !hue.cand, !mask_reg)

endmodule

### hw/rtl/hue_band_color_mask_top.sv
// A pixel passes the extrema, reciprocal, product, hue and band registers in turn before its mask transfer.
// Throughput: one pixel per clock while mask_ready stays high; each of the five stages holds one pixel.
// A stalled output fills the stages in turn before pixel_ready drops.
// Reset clears every stage valid bit and loads the threshold registers with their defaults.
// Top level of the hue band color mask: configuration registers and the pipeline.
`include "hue_band_color_mask_top_macros.svh"

module hue_band_color_mask_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pixel_valid,
    output logic                             pixel_ready,
    input  logic [hbcm_pkg::CHAN_W-1:0]      blue,
    input  logic [hbcm_pkg::CHAN_W-1:0]      green,
    input  logic [hbcm_pkg::CHAN_W-1:0]      red,
    input  logic                             last_pixel,
    output logic                             mask_valid,
    input  logic                             mask_ready,
    output logic                             mask_on,
    output logic                             last_out,
    input  logic                             cfg_write,
    input  logic [hbcm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hbcm_pkg::CHAN_W-1:0]      cfg_data
);

    hbcm_pkg::cfg_t  cfg_reg;
    hbcm_pkg::cfg_t  cfg_next;
    logic            sect_valid;
    logic            sect_ready;
    hbcm_pkg::sect_t sect;
    logic            hue_valid;
    logic            hue_ready;
    hbcm_pkg::hue_t  hue;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                hbcm_pkg::REG_BAND_SELECT: cfg_next.band_select = cfg_data[0];
                hbcm_pkg::REG_INNER_LOW:   cfg_next.inner_low   = cfg_data;
                hbcm_pkg::REG_INNER_HIGH:  cfg_next.inner_high  = cfg_data;
                hbcm_pkg::REG_WRAP_ABOVE:  cfg_next.wrap_above  = cfg_data;
                hbcm_pkg::REG_WRAP_BELOW:  cfg_next.wrap_below  = cfg_data;
                hbcm_pkg::REG_CHROMA_MIN:  cfg_next.chroma_min  = cfg_data;
                hbcm_pkg::REG_LIGHT_MIN:   cfg_next.light_min   = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band_select <= hbcm_pkg::RST_BAND_SELECT;
            cfg_reg.inner_low   <= hbcm_pkg::RST_INNER_LOW;
            cfg_reg.inner_high  <= hbcm_pkg::RST_INNER_HIGH;
            cfg_reg.wrap_above  <= hbcm_pkg::RST_WRAP_ABOVE;
            cfg_reg.wrap_below  <= hbcm_pkg::RST_WRAP_BELOW;
            cfg_reg.chroma_min  <= hbcm_pkg::RST_CHROMA_MIN;
            cfg_reg.light_min   <= hbcm_pkg::RST_LIGHT_MIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hbcm_extrema u_extrema
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pix_valid  (pixel_valid),
        .pix_ready  (pixel_ready),
        .blue       (blue),
        .green      (green),
        .red        (red),
        .last_pixel (last_pixel),
        .sect_valid (sect_valid),
        .sect_ready (sect_ready),
        .sect       (sect)
    );

    hbcm_hue u_hue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .sect_valid (sect_valid),
        .sect_ready (sect_ready),
        .sect       (sect),
        .hue_valid  (hue_valid),
        .hue_ready  (hue_ready),
        .hue        (hue)
    );

    hbcm_band u_band
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .hue_valid  (hue_valid),
        .hue_ready  (hue_ready),
        .hue        (hue),
        .mask_valid (mask_valid),
        .mask_ready (mask_ready),
        .mask_on    (mask_on),
        .last_out   (last_out)
    );

    `HBCM_ASSERT(a_ready_when_drained, !mask_valid || mask_ready, pixel_ready)

endmodule

### dv/hue_band_color_mask_top_test.sv
// Testbench for hue_band_color_mask_top: directed and random pixels checked against a hue predictor.
module hue_band_color_mask_top_test;

    import hbcm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic mask_on;
        logic last;
    } mask_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              pixel_valid = 1'b0;
    logic              pixel_ready;
    logic [CHAN_W-1:0] blue = '0;
    logic [CHAN_W-1:0] green = '0;
    logic [CHAN_W-1:0] red = '0;
    logic              last_pixel = 1'b0;
    logic              mask_valid;
    logic              mask_ready = 1'b0;
    logic              mask_on;
    logic              last_out;
    logic              cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CHAN_W-1:0] cfg_data = '0;

    cfg_t         thresholds;
    mask_result_t pending_masks [$];
    int           error_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_request = 0;
    int           hold_count = 0;
    int           idle_cycles = 0;

    hue_band_color_mask_top u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .last_pixel  (last_pixel),
        .mask_valid  (mask_valid),
        .mask_ready  (mask_ready),
        .mask_on     (mask_on),
        .last_out    (last_out),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic cfg_t default_thresholds();
        cfg_t c;
        c.band_select = RST_BAND_SELECT;
        c.inner_low   = RST_INNER_LOW;
        c.inner_high  = RST_INNER_HIGH;
        c.wrap_above  = RST_WRAP_ABOVE;
        c.wrap_below  = RST_WRAP_BELOW;
        c.chroma_min  = RST_CHROMA_MIN;
        c.light_min   = RST_LIGHT_MIN;
        return c;
    endfunction

    function automatic logic hue_mask_of(input cfg_t c, input logic [CHAN_W-1:0] b,
                                         input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] r);
        int     vmax;
        int     vmin;
        int     diff;
        int     light;
        longint num;
        longint recip;
        longint hue;
        vmax = int'(b);
        vmin = int'(b);
        if (int'(g) > vmax) vmax = int'(g);
        if (int'(r) > vmax) vmax = int'(r);
        if (int'(g) < vmin) vmin = int'(g);
        if (int'(r) < vmin) vmin = int'(r);
        diff = vmax - vmin;
        light = (vmax + vmin) >>> 1;
        if (!(diff > int'(c.chroma_min) && light > int'(c.light_min)))
            return 1'b0;
        if (vmax == int'(r))
            num = longint'(g) - longint'(b);
        else if (vmax == int'(g))
            num = longint'(b) - longint'(r) + 2 * diff;
        else
            num = longint'(r) - longint'(g) + 4 * diff;
        recip = (longint'(RECIP_NUM) + diff / 2) / diff;
        hue = (num * recip * 15 + longint'(HUE_ROUND)) >>> HUE_SHIFT;
        if (hue < 0)
            hue = hue + 180;
        if (c.band_select)
            return hue > longint'(c.inner_low) && hue < longint'(c.inner_high);
        return hue > longint'(c.wrap_above) || hue < longint'(c.wrap_below);
    endfunction

    // Tracks register writes, predicts each accepted pixel and checks each mask transfer.
    always @(posedge clk)
    begin
        mask_result_t want;
        if (!rst_n)
        begin
            thresholds = default_thresholds();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BAND_SELECT: thresholds.band_select = cfg_data[0];
                    REG_INNER_LOW:   thresholds.inner_low = cfg_data;
                    REG_INNER_HIGH:  thresholds.inner_high = cfg_data;
                    REG_WRAP_ABOVE:  thresholds.wrap_above = cfg_data;
                    REG_WRAP_BELOW:  thresholds.wrap_below = cfg_data;
                    REG_CHROMA_MIN:  thresholds.chroma_min = cfg_data;
                    REG_LIGHT_MIN:   thresholds.light_min = cfg_data;
                    default: ;
                endcase
            end
            if (pixel_valid && pixel_ready)
            begin
                want.mask_on = hue_mask_of(thresholds, blue, green, red);
                want.last = last_pixel;
                pending_masks.push_back(want);
            end
            if (mask_valid && mask_ready)
            begin
                if (pending_masks.size() == 0)
                begin
                    $display("%0t: mask transfer with no pixel pending: mask_on=%0b last_out=%0b",
                             $time, mask_on, last_out);
                    error_count++;
                end
                else
                begin
                    want = pending_masks.pop_front();
                    if (mask_on !== want.mask_on)
                    begin
                        $display("%0t: mask_on mismatch: expected %0b, actual %0b",
                                 $time, want.mask_on, mask_on);
                        error_count++;
                    end
                    if (last_out !== want.last)
                    begin
                        $display("%0t: last_out mismatch: expected %0b, actual %0b",
                                 $time, want.last, last_out);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_count < hold_request)
        begin
            mask_ready <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
        begin
            mask_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (pixel_valid && pixel_ready) || (mask_valid && mask_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_pixel(input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] r, input logic lp);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        blue <= b;
        green <= g;
        red <= r;
        last_pixel <= lp;
        do
            @(posedge clk);
        while (!pixel_ready);
    endtask

    task automatic send_random_pixel();
        logic [CHAN_W-1:0] peak;
        logic [CHAN_W-1:0] ch [3];
        if ($urandom_range(0, 9) < 7)
        begin
            peak = CHAN_W'($urandom_range(90, 255));
            for (int i = 0; i < 3; i++)
                ch[i] = peak - CHAN_W'($urandom_range(0, peak));
            ch[$urandom_range(0, 2)] = peak;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
                ch[i] = CHAN_W'($urandom_range(0, 255));
        end
        send_pixel(ch[0], ch[1], ch[2], 1'($urandom_range(0, 1)));
    endtask

    // The first wait lets the checker record the transfer of the last pixel.
    task automatic drain_masks();
        pixel_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_masks.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CHAN_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic load_thresholds(input cfg_t c);
        write_register(REG_BAND_SELECT, {7'($urandom_range(0, 127)), c.band_select});
        write_register(REG_INNER_LOW, c.inner_low);
        write_register(REG_INNER_HIGH, c.inner_high);
        write_register(REG_WRAP_ABOVE, c.wrap_above);
        write_register(REG_WRAP_BELOW, c.wrap_below);
        write_register(REG_CHROMA_MIN, c.chroma_min);
        write_register(REG_LIGHT_MIN, c.light_min);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic cfg_t random_thresholds();
        cfg_t c;
        c.band_select = 1'($urandom_range(0, 1));
        c.inner_low   = CHAN_W'($urandom_range(0, 180));
        c.inner_high  = CHAN_W'($urandom_range(0, 180));
        c.wrap_above  = CHAN_W'($urandom_range(0, 180));
        c.wrap_below  = CHAN_W'($urandom_range(0, 180));
        c.chroma_min  = CHAN_W'($urandom_range(0, 60));
        c.light_min   = CHAN_W'($urandom_range(0, 160));
        if ($urandom_range(0, 4) == 0)
            c.inner_high = CHAN_W'($urandom_range(181, 255));
        return c;
    endfunction

    task automatic send_directed_pixels();
        logic [3*CHAN_W-1:0] corner_px [12] = '{
            {8'd0,   8'd0,   8'd0},   {8'd255, 8'd255, 8'd255},
            {8'd0,   8'd0,   8'd255}, {8'd255, 8'd0,   8'd0},
            {8'd0,   8'd255, 8'd0},   {8'd200, 8'd100, 8'd255},
            {8'd255, 8'd255, 8'd0},   {8'd255, 8'd200, 8'd100},
            {8'd120, 8'd120, 8'd130}, {8'd120, 8'd120, 8'd131},
            {8'd100, 8'd110, 8'd121}, {8'd0,   8'd255, 8'd255}
        };
        for (int i = 0; i < 12; i++)
            send_pixel(corner_px[i][23:16], corner_px[i][15:8], corner_px[i][7:0], i[0]);
        drain_masks();
    endtask

    // Reset thresholds in both band modes: color corners, ties, weak pixels and negative hues.
    task automatic test_directed_pixels();
        cfg_t c;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_directed_pixels();
        c = default_thresholds();
        c.band_select = 1'b0;
        load_thresholds(c);
        send_directed_pixels();
    endtask

    // Thresholds at their extremes, above the hue range, and a write to an unmapped index.
    task automatic test_threshold_extremes();
        cfg_t c;
        send_idle_pct = 10;
        recv_idle_pct = 10;
        c = '{band_select: 1'b1, inner_low: 8'd0, inner_high: 8'd255, wrap_above: 8'd0,
              wrap_below: 8'd180, chroma_min: 8'd0, light_min: 8'd0};
        load_thresholds(c);
        write_register(REG_UNMAPPED, 8'hff);
        cfg_write <= 1'b0;
        @(posedge clk);
        repeat (50) send_random_pixel();
        drain_masks();
        c.band_select = 1'b0;
        load_thresholds(c);
        repeat (50) send_random_pixel();
        drain_masks();
        c = '{band_select: 1'b0, inner_low: 8'd255, inner_high: 8'd0, wrap_above: 8'd255,
              wrap_below: 8'd0, chroma_min: 8'd0, light_min: 8'd0};
        load_thresholds(c);
        repeat (50) send_random_pixel();
        drain_masks();
        c = '{band_select: 1'b1, inner_low: 8'd0, inner_high: 8'd180, wrap_above: 8'd180,
              wrap_below: 8'd0, chroma_min: 8'd255, light_min: 8'd255};
        load_thresholds(c);
        repeat (50) send_random_pixel();
        drain_masks();
    endtask

    task automatic test_random_traffic();
        int idle_plan [3][2] = '{'{25, 45}, '{45, 25}, '{0, 0}};
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = idle_plan[p][0];
            recv_idle_pct = idle_plan[p][1];
            repeat (3)
            begin
                load_thresholds(random_thresholds());
                repeat (70) send_random_pixel();
                drain_masks();
            end
        end
    endtask

    // The mask side holds off long enough for the pipeline to fill and stall the pixel side.
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 20;
        load_thresholds(random_thresholds());
        hold_request = HOLD_CYCLES;
        repeat (40) send_random_pixel();
        drain_masks();
    endtask

    initial
    begin
        thresholds = default_thresholds();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_pixels();
        test_threshold_extremes();
        test_random_traffic();
        test_output_stall();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
